// ----- src/oiss_pkg.sv -----
// Package for the owned index set: sizes, opcodes, outcome codes, channel payloads,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package oiss_pkg;

    localparam int MAX_ENTRIES   = 32;
    localparam int INDEX_BITS    = 16;
    localparam int OWNER_W       = 32;
    localparam int ITEM_W        = 16;
    localparam int COUNT_FIELD_W = 6;
    localparam int CNT_W         = $clog2(MAX_ENTRIES + 1);
    localparam int ADDR_W        = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    localparam logic [OWNER_W-1:0] OWNER_NONE = '1;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_TOGGLE = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        OUT_ADDED     = 3'd0,
        OUT_REMOVED   = 3'd1,
        OUT_DUPLICATE = 3'd2,
        OUT_FULL      = 3'd3,
        OUT_MISS      = 3'd4,
        OUT_CLEARED   = 3'd5
    } outcome_t;

    typedef struct packed {
        op_t                opcode;
        logic [OWNER_W-1:0] owner_id;
        logic [ITEM_W-1:0]  item_index;
    } req_t;

    typedef struct packed {
        logic [2:0]               outcome;
        logic [COUNT_FIELD_W-1:0] entry_count;
        logic [OWNER_W-1:0]       current_owner;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_SCAN,
        ST_FETCH_LAST,
        ST_SWAP,
        ST_APPEND,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic     load_req;
        logic     start;
        logic     scan;
        logic     fetch_last;
        logic     swap;
        logic     append;
        logic     set_outcome;
        outcome_t outcome;
        logic     load_out;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic owner_match;
        logic hit;
        logic scan_end;
        logic full;
        logic out_free;
    } stat_t;

    // Keep the low INDEX_BITS bits of the index field, zero above the field.
    function automatic logic [INDEX_BITS-1:0] to_index(input logic [ITEM_W-1:0] x);
        logic [INDEX_BITS-1:0] r;
        r = '0;
        for (int i = 0; i < INDEX_BITS; i++) begin
            if (i < ITEM_W) begin
                r[i] = x[i];
            end
        end
        return r;
    endfunction

    // Fit the held count into the result field, truncating or zero extending.
    function automatic logic [COUNT_FIELD_W-1:0] fit_count(input logic [CNT_W-1:0] c);
        logic [COUNT_FIELD_W-1:0] r;
        r = '0;
        for (int i = 0; i < COUNT_FIELD_W; i++) begin
            if (i < CNT_W) begin
                r[i] = c[i];
            end
        end
        return r;
    endfunction

endpackage

// ----- src/owned_index_set_swap_remove.sv -----
// Top level of the owned index set with swap-remove: joins controller and datapath.
// Uses oiss_pkg, oiss_ctrl, oiss_dp (which holds the entry RAM oiss_ram).
//
//   channel  dir  ports                       payload
//   request  in   s_valid, s_ready, s_req     oiss_pkg::req_t (opcode, owner_id, item_index)
//   result   out  m_valid, m_ready, m_rsp     oiss_pkg::rsp_t (outcome, entry_count, owner)
//
// One request at a time: accept, owner check, then a scan over the held entries through
// the registered RAM read that stops at the first match; then fetch-last and swap for a
// swap-remove or an append where the scan calls for one, and last the result register
// load. Clear and wrong-owner remove go from the owner check straight to the result.
// Synchronous active-low reset empties the set and sets the owner to none; no sweep.
// A result waiting on m_ready holds the block in its final step; a new request is taken
// while the previous result is still held.
`timescale 1ns / 1ps

module owned_index_set_swap_remove (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  oiss_pkg::req_t s_req,
    output logic           m_valid,
    input  logic           m_ready,
    output oiss_pkg::rsp_t m_rsp
);

    oiss_pkg::cmd_t  cmd;
    oiss_pkg::stat_t stat;

    oiss_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .stat   (stat),
        .cmd    (cmd)
    );

    oiss_dp u_dp (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_req  (s_req),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_rsp  (m_rsp),
        .cmd    (cmd),
        .stat   (stat)
    );

endmodule

// ----- src/oiss_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module oiss_ram #(
    parameter int  WIDTH = 16,
    parameter int  DEPTH = 32,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/oiss_ctrl.sv -----
// Controller for the owned index set: sequences accept, owner check, scan,
// swap-remove or append, and result hand-off. Uses oiss_pkg.
`timescale 1ns / 1ps

module oiss_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  oiss_pkg::stat_t stat,
    output oiss_pkg::cmd_t  cmd
);

    oiss_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= oiss_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            oiss_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = oiss_pkg::ST_START;
                end
            end
            oiss_pkg::ST_START: begin
                priority if (stat.op == oiss_pkg::OP_CLEAR) begin
                    state_next = oiss_pkg::ST_RESULT;
                end else if (stat.op == oiss_pkg::OP_REMOVE && !stat.owner_match) begin
                    state_next = oiss_pkg::ST_RESULT;
                end else begin
                    state_next = oiss_pkg::ST_SCAN;
                end
            end
            oiss_pkg::ST_SCAN: begin
                priority if (stat.hit) begin
                    state_next = (stat.op == oiss_pkg::OP_ADD) ? oiss_pkg::ST_RESULT
                                                               : oiss_pkg::ST_FETCH_LAST;
                end else if (stat.scan_end) begin
                    if (stat.op == oiss_pkg::OP_REMOVE || stat.full) begin
                        state_next = oiss_pkg::ST_RESULT;
                    end else begin
                        state_next = oiss_pkg::ST_APPEND;
                    end
                end else begin
                    state_next = oiss_pkg::ST_SCAN;
                end
            end
            oiss_pkg::ST_FETCH_LAST: state_next = oiss_pkg::ST_SWAP;
            oiss_pkg::ST_SWAP:       state_next = oiss_pkg::ST_RESULT;
            oiss_pkg::ST_APPEND:     state_next = oiss_pkg::ST_RESULT;
            oiss_pkg::ST_RESULT: begin
                if (stat.out_free) begin
                    state_next = oiss_pkg::ST_IDLE;
                end
            end
            default: state_next = oiss_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            oiss_pkg::ST_IDLE: begin
                s_ready      = 1'b1;
                cmd.load_req = s_valid;
            end
            oiss_pkg::ST_START: begin
                cmd.start = 1'b1;
                priority if (stat.op == oiss_pkg::OP_CLEAR) begin
                    cmd.set_outcome = 1'b1;
                    cmd.outcome     = oiss_pkg::OUT_CLEARED;
                end else if (stat.op == oiss_pkg::OP_REMOVE && !stat.owner_match) begin
                    cmd.set_outcome = 1'b1;
                    cmd.outcome     = oiss_pkg::OUT_MISS;
                end else begin
                    cmd.set_outcome = 1'b0;
                end
            end
            oiss_pkg::ST_SCAN: begin
                cmd.scan = 1'b1;
                priority if (stat.hit) begin
                    if (stat.op == oiss_pkg::OP_ADD) begin
                        cmd.set_outcome = 1'b1;
                        cmd.outcome     = oiss_pkg::OUT_DUPLICATE;
                    end
                end else if (stat.scan_end) begin
                    if (stat.op == oiss_pkg::OP_REMOVE) begin
                        cmd.set_outcome = 1'b1;
                        cmd.outcome     = oiss_pkg::OUT_MISS;
                    end else if (stat.full) begin
                        cmd.set_outcome = 1'b1;
                        cmd.outcome     = oiss_pkg::OUT_FULL;
                    end
                end else begin
                    cmd.set_outcome = 1'b0;
                end
            end
            oiss_pkg::ST_FETCH_LAST: cmd.fetch_last = 1'b1;
            oiss_pkg::ST_SWAP: begin
                cmd.swap        = 1'b1;
                cmd.set_outcome = 1'b1;
                cmd.outcome     = oiss_pkg::OUT_REMOVED;
            end
            oiss_pkg::ST_APPEND: begin
                cmd.append      = 1'b1;
                cmd.set_outcome = 1'b1;
                cmd.outcome     = oiss_pkg::OUT_ADDED;
            end
            oiss_pkg::ST_RESULT: cmd.load_out = stat.out_free;
            default: cmd = '0;
        endcase
    end

endmodule

// ----- src/oiss_dp.sv -----
// Datapath for the owned index set: owner and count registers, request latch,
// scan pointer, entry RAM and result register. Uses oiss_pkg and oiss_ram.
`timescale 1ns / 1ps

module oiss_dp (
    input  logic            aclk,
    input  logic            aresetn,
    input  oiss_pkg::req_t  s_req,
    output logic            m_valid,
    input  logic            m_ready,
    output oiss_pkg::rsp_t  m_rsp,
    input  oiss_pkg::cmd_t  cmd,
    output oiss_pkg::stat_t stat
);

    localparam int AW = oiss_pkg::ADDR_W;
    localparam int CW = oiss_pkg::CNT_W;
    localparam int IW = oiss_pkg::INDEX_BITS;
    localparam logic [CW-1:0] CNT_MAX = CW'(oiss_pkg::MAX_ENTRIES);
    localparam logic [CW-1:0] CNT_ONE = CW'(1);

    logic [oiss_pkg::OWNER_W-1:0] owner_reg, owner_next;
    logic [CW-1:0]                count_reg, count_next;
    oiss_pkg::op_t                op_reg;
    logic [oiss_pkg::OWNER_W-1:0] who_reg;
    logic [IW-1:0]                idx_reg;
    logic [CW-1:0]                ptr_reg, ptr_next;
    logic                         cmp_valid_reg, cmp_valid_next;
    logic [AW-1:0]                cmp_ptr_reg, cmp_ptr_next;
    logic [AW-1:0]                hit_ptr_reg, hit_ptr_next;
    logic [2:0]                   outcome_reg;
    logic                         m_valid_reg;
    oiss_pkg::rsp_t               m_rsp_reg;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [IW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [IW-1:0] ram_rdata;
    logic [CW-1:0] last_pos;

    assign last_pos = count_reg - CNT_ONE;

    assign stat.op          = op_reg;
    assign stat.owner_match = (owner_reg == who_reg);
    assign stat.hit         = cmp_valid_reg && (ram_rdata == idx_reg);
    assign stat.scan_end    = !cmp_valid_reg && (ptr_reg >= count_reg);
    assign stat.full        = (count_reg >= CNT_MAX);
    assign stat.out_free    = !m_valid_reg || m_ready;

    // Owner, count and scan pointer
    always_comb begin
        owner_next     = owner_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        cmp_valid_next = 1'b0;
        cmp_ptr_next   = cmp_ptr_reg;
        hit_ptr_next   = hit_ptr_reg;
        if (cmd.start) begin
            ptr_next = '0;
            priority if (op_reg == oiss_pkg::OP_CLEAR) begin
                owner_next = oiss_pkg::OWNER_NONE;
                count_next = '0;
            end else if (op_reg != oiss_pkg::OP_REMOVE && owner_reg != who_reg) begin
                // New owner: empty the set before the add checks
                owner_next = who_reg;
                count_next = '0;
            end else begin
                owner_next = owner_reg;
            end
        end
        if (cmd.scan) begin
            cmp_valid_next = (ptr_reg < count_reg);
            cmp_ptr_next   = ptr_reg[AW-1:0];
            if (ptr_reg < count_reg) begin
                ptr_next = ptr_reg + CNT_ONE;
            end
            if (stat.hit) begin
                hit_ptr_next = cmp_ptr_reg;
            end
        end
        if (cmd.swap) begin
            count_next = last_pos;
            if (count_reg == CNT_ONE) begin
                owner_next = oiss_pkg::OWNER_NONE;
            end
        end
        if (cmd.append) begin
            count_next = count_reg + CNT_ONE;
        end
    end

    always_comb begin
        ram_we    = cmd.swap || cmd.append;
        ram_waddr = cmd.swap ? hit_ptr_reg : count_reg[AW-1:0];
        ram_wdata = cmd.swap ? ram_rdata : idx_reg;
        ram_raddr = cmd.fetch_last ? last_pos[AW-1:0] : ptr_reg[AW-1:0];
    end

    oiss_ram #(
        .WIDTH(IW),
        .DEPTH(oiss_pkg::MAX_ENTRIES)
    ) u_entries (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            owner_reg     <= oiss_pkg::OWNER_NONE;
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            owner_reg     <= owner_next;
            count_reg     <= count_next;
            cmp_valid_reg <= cmp_valid_next;
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg     <= ptr_next;
        cmp_ptr_reg <= cmp_ptr_next;
        hit_ptr_reg <= hit_ptr_next;
        if (cmd.load_req) begin
            op_reg  <= s_req.opcode;
            who_reg <= s_req.owner_id;
            idx_reg <= oiss_pkg::to_index(s_req.item_index);
        end
        if (cmd.set_outcome) begin
            outcome_reg <= cmd.outcome;
        end
        if (cmd.load_out) begin
            m_rsp_reg.outcome       <= outcome_reg;
            m_rsp_reg.entry_count   <= oiss_pkg::fit_count(count_reg);
            m_rsp_reg.current_owner <= owner_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_rsp   = m_rsp_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_MAX)
        else $error("held count above capacity");

    a_append_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.append |=> count_reg == $past(count_reg) + CNT_ONE)
        else $error("append did not advance the count");

    a_empty_frees_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.swap && count_reg == CNT_ONE |=> owner_reg == oiss_pkg::OWNER_NONE)
        else $error("owner kept after last entry removed");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten while held");

    a_swap_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.fetch_last || cmd.swap) |-> count_reg != '0)
        else $error("swap-remove on an empty set");

endmodule

// ----- tb/sv/oiss_set_checker.sv -----
// Checker for the owned index set: tracks its own copy of owner, count and entries,
// queues one expected result per request transaction and compares result transactions.
// Depends on oiss_pkg for payload types, opcodes, outcome codes and sizes.
`timescale 1ns / 1ps

module oiss_set_checker
    import oiss_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    input  logic s_ready,
    input  req_t s_req,
    input  logic m_valid,
    input  logic m_ready,
    input  rsp_t m_rsp,
    output int   fail_count,
    output int   pending,
    output int   checked,
    output int   full_count
);

    logic [OWNER_W-1:0]    set_owner;
    int                    held;
    logic [INDEX_BITS-1:0] set_entries [MAX_ENTRIES];
    rsp_t                  expected_results [$];

    initial begin
        fail_count = 0;
        pending    = 0;
        checked    = 0;
        full_count = 0;
        set_owner  = OWNER_NONE;
        held       = 0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, want);
        fail_count = fail_count + 1;
    endtask

    function automatic outcome_t try_add(input logic [OWNER_W-1:0] who,
                                         input logic [INDEX_BITS-1:0] idx);
        // a new owner empties the set before any other check
        if (set_owner != who) begin
            held      = 0;
            set_owner = who;
        end
        for (int i = 0; i < held; i++) begin
            if (set_entries[i] == idx) begin
                return OUT_DUPLICATE;
            end
        end
        if (held >= MAX_ENTRIES) begin
            return OUT_FULL;
        end
        set_entries[held] = idx;
        held = held + 1;
        return OUT_ADDED;
    endfunction

    function automatic bit try_remove(input logic [OWNER_W-1:0] who,
                                      input logic [INDEX_BITS-1:0] idx);
        if (set_owner != who) begin
            return 1'b0;
        end
        for (int i = 0; i < held; i++) begin
            if (set_entries[i] == idx) begin
                // swap the last entry into the hole
                set_entries[i] = set_entries[held-1];
                held = held - 1;
                if (held == 0) begin
                    set_owner = OWNER_NONE;
                end
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic rsp_t next_result(input req_t r);
        rsp_t                  res;
        outcome_t              oc;
        logic [INDEX_BITS-1:0] idx;
        idx = r.item_index[INDEX_BITS-1:0];
        case (r.opcode)
            OP_ADD: begin
                oc = try_add(r.owner_id, idx);
            end
            OP_REMOVE: begin
                oc = try_remove(r.owner_id, idx) ? OUT_REMOVED : OUT_MISS;
            end
            OP_TOGGLE: begin
                if (try_remove(r.owner_id, idx)) begin
                    oc = OUT_REMOVED;
                end else begin
                    oc = try_add(r.owner_id, idx);
                end
            end
            default: begin
                set_owner = OWNER_NONE;
                held      = 0;
                oc        = OUT_CLEARED;
            end
        endcase
        res.outcome       = oc;
        res.entry_count   = held[COUNT_FIELD_W-1:0];
        res.current_owner = set_owner;
        return res;
    endfunction

    always @(posedge aclk) begin
        rsp_t want;
        if (!aresetn) begin
            set_owner = OWNER_NONE;
            held      = 0;
            expected_results.delete();
        end else begin
            if (s_valid && s_ready) begin
                expected_results.push_back(next_result(s_req));
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", 32'(m_rsp.outcome), 32'hFFFF_FFFF);
                end else begin
                    want = expected_results.pop_front();
                    checked = checked + 1;
                    if (want.outcome == OUT_FULL) begin
                        full_count = full_count + 1;
                    end
                    if (m_rsp.outcome !== want.outcome) begin
                        report_mismatch("outcome", 32'(m_rsp.outcome), 32'(want.outcome));
                    end
                    if (m_rsp.entry_count !== want.entry_count) begin
                        report_mismatch("entry_count", 32'(m_rsp.entry_count),
                                        32'(want.entry_count));
                    end
                    if (m_rsp.current_owner !== want.current_owner) begin
                        report_mismatch("current_owner", m_rsp.current_owner,
                                        want.current_owner);
                    end
                end
            end
        end
        pending = expected_results.size();
    end

endmodule

// ----- tb/sv/owned_index_set_swap_remove_tb.sv -----
// Top of the owned index set testbench: clock, reset, request and result drivers,
// directed and random request streams, and the verdict.
// Depends on oiss_pkg, owned_index_set_swap_remove and oiss_set_checker.
`timescale 1ns / 1ps

module owned_index_set_swap_remove_tb;
    import oiss_pkg::*;

    localparam logic [OWNER_W-1:0] OWNER_A    = 32'hA5C3_0F96;
    localparam logic [OWNER_W-1:0] OWNER_B    = 32'h5A3C_F069;
    localparam int                 HOLD_OFF   = 400;
    localparam int                 RAND_ITEMS = 550;
    localparam int                 DRAIN_MAX  = 20000;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    req_t s_req;
    logic m_valid;
    logic m_ready;
    rsp_t m_rsp;

    int   fail_count;
    int   pending;
    int   checked;
    int   full_count;

    int   idle_mode;
    bit   hold_off_req;
    int   sent;
    int   op_count [4];

    owned_index_set_swap_remove i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_req   (s_req),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_rsp   (m_rsp)
    );

    oiss_set_checker i_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req      (s_req),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_rsp      (m_rsp),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked),
        .full_count (full_count)
    );

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    initial begin
        #(5_000_000);
        $display("timeout with %0d results outstanding", pending);
        $display("owned_index_set_swap_remove_tb: done, errors");
        $finish;
    end

    // Result side: random ready per idle mode, plus one long hold-off.
    initial begin
        int  stall_left;
        bit  hold_taken;
        int  rx_pct;
        stall_left = 0;
        hold_taken = 1'b0;
        m_ready    = 1'b0;
        forever begin
            @(negedge aclk);
            rx_pct = (idle_mode == 0) ? 58 : (idle_mode == 1) ? 22 : 0;
            if (hold_off_req && !hold_taken) begin
                stall_left = HOLD_OFF;
                hold_taken = 1'b1;
            end
            if (stall_left > 0) begin
                m_ready    = 1'b0;
                stall_left = stall_left - 1;
            end else begin
                m_ready = ($urandom_range(99) >= rx_pct);
            end
        end
    end

    task automatic send_req(input op_t op, input logic [OWNER_W-1:0] who,
                            input logic [ITEM_W-1:0] idx);
        int tx_pct;
        int gap;
        tx_pct = (idle_mode == 0) ? 22 : (idle_mode == 1) ? 58 : 0;
        gap = 0;
        if (tx_pct > 0) begin
            // mostly short gaps, now and then one long enough to land mid-scan
            if ($urandom_range(99) < 10) begin
                gap = $urandom_range(1, 45);
            end else begin
                while ($urandom_range(99) < tx_pct) begin
                    gap = gap + 1;
                end
            end
        end
        repeat (gap) begin
            @(negedge aclk);
            s_valid = 1'b0;
        end
        @(negedge aclk);
        s_valid          = 1'b1;
        s_req.opcode     = op;
        s_req.owner_id   = who;
        s_req.item_index = idx;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        sent = sent + 1;
        op_count[op] = op_count[op] + 1;
    endtask

    initial begin
        logic [OWNER_W-1:0] owner_pool [4];
        logic [OWNER_W-1:0] who;
        logic [ITEM_W-1:0]  base;
        int                 kind;
        int                 len;
        int                 waited;

        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_req        = '0;
        idle_mode    = 0;
        hold_off_req = 1'b0;
        sent         = 0;
        op_count     = '{default: 0};

        repeat (7) @(negedge aclk);
        aresetn = 1'b1;

        // directed: empty set, duplicates, toggles, owner switches, none owner, clear
        send_req(OP_REMOVE, OWNER_A, 16'h0000);
        send_req(OP_REMOVE, OWNER_NONE, 16'h0000);
        send_req(OP_ADD, OWNER_A, 16'h0000);
        send_req(OP_ADD, OWNER_A, 16'h0000);
        send_req(OP_ADD, OWNER_A, 16'hFFFF);
        send_req(OP_TOGGLE, OWNER_A, 16'hFFFF);
        send_req(OP_TOGGLE, OWNER_A, 16'h1234);
        send_req(OP_REMOVE, OWNER_B, 16'h0000);
        send_req(OP_REMOVE, OWNER_A, 16'h5555);
        send_req(OP_ADD, OWNER_B, 16'h0000);
        send_req(OP_ADD, OWNER_B, 16'h0000);
        send_req(OP_ADD, OWNER_NONE, 16'hAAAA);
        send_req(OP_ADD, OWNER_NONE, 16'h5555);
        send_req(OP_REMOVE, OWNER_NONE, 16'hAAAA);
        send_req(OP_REMOVE, OWNER_NONE, 16'h5555);
        send_req(OP_ADD, 32'h0000_0000, 16'h0007);
        send_req(OP_TOGGLE, 32'h0000_0001, 16'h0007);
        send_req(OP_REMOVE, 32'h0000_0001, 16'h0007);
        send_req(OP_CLEAR, $urandom, 16'($urandom));
        send_req(OP_ADD, OWNER_A, 16'h0001);
        send_req(OP_CLEAR, OWNER_NONE, 16'hFFFF);
        send_req(OP_TOGGLE, OWNER_B, 16'h0009);
        send_req(OP_ADD, OWNER_A, 16'h0009);

        owner_pool[0] = $urandom;
        owner_pool[1] = $urandom;
        owner_pool[2] = 32'h0000_0000;
        owner_pool[3] = OWNER_NONE;

        while (sent < RAND_ITEMS) begin
            if (sent > 2 * RAND_ITEMS / 3) begin
                idle_mode = 2;
            end else if (sent > RAND_ITEMS / 3) begin
                idle_mode = 1;
            end
            if (sent > 120) begin
                hold_off_req = 1'b1;
            end
            who  = owner_pool[$urandom_range(3)];
            base = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(3) * 16);
            kind = $urandom_range(99);
            if (kind < 40) begin
                // churn on a small window, mostly one owner
                len = $urandom_range(8, 20);
                repeat (len) begin
                    if ($urandom_range(9) == 0) begin
                        who = owner_pool[$urandom_range(3)];
                    end
                    send_req(op_t'($urandom_range(2)), who, base + 16'($urandom_range(15)));
                end
            end else if (kind < 60) begin
                // fill to capacity or past it, then knock some entries out
                if ($urandom_range(2) == 0) begin
                    send_req(OP_CLEAR, $urandom, 16'($urandom));
                end
                len = $urandom_range(32, 36);
                for (int i = 0; i < len; i++) begin
                    send_req(OP_ADD, who, base + 16'(i));
                end
                send_req(OP_ADD, who, base);
                len = $urandom_range(4, 12);
                repeat (len) begin
                    send_req(op_t'($urandom_range(1) ? OP_REMOVE : OP_TOGGLE), who,
                             base + 16'($urandom_range(40)));
                end
            end else if (kind < 75) begin
                // sweep removes over the window
                len = $urandom_range(4, 16);
                for (int i = 0; i < len; i++) begin
                    send_req(OP_REMOVE, who, base + 16'(i));
                end
            end else if (kind < 92) begin
                // noise: every field fully random
                len = $urandom_range(1, 5);
                repeat (len) begin
                    send_req(op_t'($urandom_range(3)), $urandom, 16'($urandom));
                end
            end else begin
                send_req(OP_CLEAR, $urandom, 16'($urandom));
                send_req(OP_REMOVE, who, base);
            end
        end

        @(negedge aclk);
        s_valid = 1'b0;

        waited = 0;
        while (pending != 0 && waited < DRAIN_MAX) begin
            @(posedge aclk);
            waited = waited + 1;
        end
        repeat (50) @(posedge aclk);

        if (pending != 0) begin
            $display("%0d expected results never arrived", pending);
        end
        $display("sent %0d requests (add %0d, remove %0d, toggle %0d, clear %0d)",
                 sent, op_count[OP_ADD], op_count[OP_REMOVE], op_count[OP_TOGGLE],
                 op_count[OP_CLEAR]);
        $display("checked %0d results, %0d full rejections, under three idle mixes",
                 checked, full_count);
        if (fail_count == 0 && pending == 0) begin
            $display("owned_index_set_swap_remove_tb: done, clean");
        end else begin
            $display("owned_index_set_swap_remove_tb: done, errors");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/oiss_pkg.sv
src/oiss_ram.sv
src/oiss_ctrl.sv
src/oiss_dp.sv
src/owned_index_set_swap_remove.sv
tb/sv/oiss_set_checker.sv
tb/sv/owned_index_set_swap_remove_tb.sv
